[src/kwm_pkg.sv]
// Shared types and defaults for the k-way sorted merge core
package kwm_pkg;

	// Default geometry
	localparam int unsigned LISTS_DEF      = 8;
	localparam int unsigned LIST_DEPTH_DEF = 64;

	// Request codes
	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_TAKE   = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DELIVER
	} state_t;

	// Request item
	typedef struct packed {
		logic [1:0]         mode;
		logic [2:0]         list_id;
		logic signed [31:0] value;
	} req_item_t;

	// Response item
	typedef struct packed {
		logic signed [31:0] min_value;
		logic [2:0]         source_list;
		logic               empty_res;
	} rsp_item_t;

	// Search token handed from cell to cell (winner index travels beside it)
	typedef struct packed {
		logic               vld;
		logic               found;
		logic signed [31:0] val;
	} token_t;

	// Broadcast commands from the controller to every cell
	typedef struct packed {
		logic               wr;
		logic               clr;
		logic               adv;
		logic [2:0]         list_id;
		logic signed [31:0] value;
	} cell_cmd_t;

endpackage

[src/k_way_sorted_merge_core.sv]
// K-way sorted merge core: controller and chain of list cells
//
//   channel | direction | handshake            | item
//   req     | in        | req_valid/req_ready  | mode, list_id, value
//   rsp     | out       | rsp_valid/rsp_ready  | min_value, source_list, empty_res
//
// Append, clear and unused-mode items are applied in the cycle they are accepted.
// A take item runs in steps: accept it and launch the search token, pass the token
// through one register per list cell as it walks the chain, capture the winner and
// post the response.
// A response waiting in the output register does not block appends or clears;
// a further take holds in its last step until that register is free.
// arst_n clears all fill counts and read positions; entry stores are not cleared.
module k_way_sorted_merge_core #(
	parameter int unsigned LISTS      = kwm_pkg::LISTS_DEF,
	parameter int unsigned LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  kwm_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output kwm_pkg::rsp_item_t rsp
);
	import kwm_pkg::*;

	localparam int unsigned IDX_W = $clog2(LISTS);

	state_t             state_q;
	state_t             state_d;
	logic               req_acc;
	logic               start_q;
	cell_cmd_t          cmd;
	token_t             tok   [LISTS+1];
	logic [IDX_W-1:0]   idx   [LISTS+1];
	logic [LISTS-1:0]   tok_vld_vec;
	logic               res_found_q;
	logic signed [31:0] res_val_q;
	logic [IDX_W-1:0]   res_idx_q;
	logic               capture;
	logic               post;
	logic               rsp_valid_q;
	rsp_item_t          rsp_q;

	assign req_acc = req_valid && req_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and broadcast commands
	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		capture     = 1'b0;
		post        = 1'b0;
		cmd.wr      = 1'b0;
		cmd.clr     = 1'b0;
		cmd.adv     = 1'b0;
		cmd.list_id = req.list_id;
		cmd.value   = req.value;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					case (req.mode)
						MODE_APPEND: cmd.wr = 1'b1;
						MODE_CLEAR:  cmd.clr = 1'b1;
						MODE_TAKE:   state_d = ST_SEARCH;
						default:     ;
					endcase
				end
			end
			ST_SEARCH: begin
				if (tok[LISTS].vld) begin
					capture = 1'b1;
					state_d = ST_DELIVER;
				end
			end
			ST_DELIVER: begin
				if (!rsp_valid_q || rsp_ready) begin
					post    = 1'b1;
					cmd.adv = res_found_q;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Token launch, in the cycle after the take is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
		end else begin
			start_q <= req_acc && (req.mode == MODE_TAKE);
		end
	end

	assign tok[0] = '{vld: start_q, found: 1'b0, val: 32'sd0};
	assign idx[0] = '0;

	// Chain of list cells
	for (genvar k = 0; k < LISTS; k++) begin : g_cell
		kwm_cell #(
			.LISTS      (LISTS),
			.LIST_DEPTH (LIST_DEPTH),
			.CELL_ID    (k),
			.IDX_W      (IDX_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.adv_idx (res_idx_q),
			.tok_in  (tok[k]),
			.idx_in  (idx[k]),
			.tok_out (tok[k+1]),
			.idx_out (idx[k+1])
		);
		assign tok_vld_vec[k] = tok[k+1].vld;
	end

	// Search result held until posted
	always_ff @(posedge clk) begin
		if (capture) begin
			res_found_q <= tok[LISTS].found;
			res_val_q   <= tok[LISTS].val;
			res_idx_q   <= idx[LISTS];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (post) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (post) begin
			rsp_q.min_value   <= res_found_q ? res_val_q : 32'sd0;
			rsp_q.source_list <= res_found_q ? 3'(res_idx_q) : 3'd0;
			rsp_q.empty_res   <= !res_found_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Only one search token in the chain at a time
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({start_q, tok_vld_vec}))
		else $error("more than one search token in flight");

	// The token leaves the chain only while a search is running
	a_tok_exit: assert property (@(posedge clk) disable iff (!arst_n)
		tok[LISTS].vld |-> (state_q == ST_SEARCH))
		else $error("search token left the chain outside a search");

	// A response is posted only from the delivery step
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_DELIVER))
		else $error("response raised outside delivery");

	// A take moves the controller into the search
	a_take_search: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.mode == MODE_TAKE) |=> (state_q == ST_SEARCH && start_q))
		else $error("accepted take did not launch a search");

endmodule

[src/kwm_cell.sv]
// One list of the merge chain: entry store, counters and a compare stage
module kwm_cell #(
	parameter int unsigned LISTS      = kwm_pkg::LISTS_DEF,
	parameter int unsigned LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF,
	parameter int unsigned CELL_ID    = 0,
	parameter int unsigned IDX_W      = $clog2(LISTS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kwm_pkg::cell_cmd_t cmd,
	input  logic [IDX_W-1:0]   adv_idx,
	input  kwm_pkg::token_t    tok_in,
	input  logic [IDX_W-1:0]   idx_in,
	output kwm_pkg::token_t    tok_out,
	output logic [IDX_W-1:0]   idx_out
);
	import kwm_pkg::*;

	localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
	localparam int unsigned AW = $clog2(LIST_DEPTH);

	logic signed [31:0] mem [LIST_DEPTH];
	logic signed [31:0] head_q;
	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      rd_q;
	logic               wr_hit;
	logic               adv_hit;
	logic               avail;
	logic               take;
	logic               tok_vld_q;
	logic               tok_found_q;
	logic signed [31:0] tok_val_q;
	logic [IDX_W-1:0]   idx_q;

	// Decode the broadcast for this list
	assign wr_hit  = cmd.wr && (32'(cmd.list_id) == 32'(CELL_ID)) &&
		(fill_q < CW'(LIST_DEPTH));
	assign adv_hit = cmd.adv && (adv_idx == IDX_W'(CELL_ID));
	assign avail   = rd_q < fill_q;

	// Entry store: append at the tail, head read every cycle
	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem[fill_q[AW-1:0]] <= cmd.value;
		end
		head_q <= mem[rd_q[AW-1:0]];
	end

	// Fill count and read position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rd_q   <= '0;
		end else if (cmd.clr) begin
			fill_q <= '0;
			rd_q   <= '0;
		end else begin
			if (wr_hit) begin
				fill_q <= fill_q + CW'(1);
			end
			if (adv_hit) begin
				rd_q <= rd_q + CW'(1);
			end
		end
	end

	// Compare stage: strict less-than keeps ties on the lower list
	assign take = avail && (!tok_in.found || (head_q < tok_in.val));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tok_found_q <= 1'b1;
			tok_val_q   <= head_q;
			idx_q       <= IDX_W'(CELL_ID);
		end else begin
			tok_found_q <= tok_in.found;
			tok_val_q   <= tok_in.val;
			idx_q       <= idx_in;
		end
	end

	assign tok_out = '{vld: tok_vld_q, found: tok_found_q, val: tok_val_q};
	assign idx_out = idx_q;

endmodule

[verif/tb_k_way_sorted_merge_core.sv]
// Self-checking testbench for the k-way sorted merge core
`timescale 1ns / 100ps

// Tracks list contents and read pointers, queues the expected take responses
class merge_scoreboard;
	localparam int NLISTS = kwm_pkg::LISTS_DEF;
	localparam int DEPTH  = kwm_pkg::LIST_DEPTH_DEF;

	logic signed [31:0]   entries [NLISTS][DEPTH];
	int unsigned          fill_cnt [NLISTS];
	int unsigned          read_ptr [NLISTS];
	kwm_pkg::rsp_item_t   expected_takes [$];
	int                   mismatches;

	function new();
		mismatches = 0;
		for (int k = 0; k < NLISTS; k++) begin
			fill_cnt[k] = 0;
			read_ptr[k] = 0;
		end
	endfunction

	function int pending();
		return expected_takes.size();
	endfunction

	// Update the list state for one accepted item and queue any response
	function void note_request(kwm_pkg::req_item_t item);
		kwm_pkg::rsp_item_t exp_rsp;
		bit                 found;
		int                 best;
		logic signed [31:0] best_val;
		found    = 1'b0;
		best     = 0;
		best_val = '0;
		case (item.mode)
			kwm_pkg::MODE_APPEND: begin
				// full lists drop the value
				if (item.list_id < NLISTS && fill_cnt[item.list_id] < DEPTH) begin
					entries[item.list_id][fill_cnt[item.list_id]] = item.value;
					fill_cnt[item.list_id]++;
				end
			end
			kwm_pkg::MODE_CLEAR: begin
				for (int k = 0; k < NLISTS; k++) begin
					fill_cnt[k] = 0;
					read_ptr[k] = 0;
				end
			end
			kwm_pkg::MODE_TAKE: begin
				// lowest head wins, strict compare keeps ties on the lower list
				for (int k = 0; k < NLISTS; k++) begin
					if (read_ptr[k] < fill_cnt[k]) begin
						if (!found || entries[k][read_ptr[k]] < best_val) begin
							found    = 1'b1;
							best     = k;
							best_val = entries[k][read_ptr[k]];
						end
					end
				end
				if (found) begin
					read_ptr[best]++;
					exp_rsp.min_value   = best_val;
					exp_rsp.source_list = best[2:0];
					exp_rsp.empty_res   = 1'b0;
				end else begin
					exp_rsp.min_value   = '0;
					exp_rsp.source_list = '0;
					exp_rsp.empty_res   = 1'b1;
				end
				expected_takes = {expected_takes, exp_rsp};
			end
			default: ;
		endcase
	endfunction

	// Compare one accepted response with the oldest expectation
	function void check_response(kwm_pkg::rsp_item_t got);
		kwm_pkg::rsp_item_t exp_rsp;
		if (expected_takes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected response value=%0d list=%0d empty=%0b",
					$realtime, got.min_value, got.source_list, got.empty_res);
			return;
		end
		exp_rsp = expected_takes.pop_front();
		if (got.min_value !== exp_rsp.min_value || got.source_list !== exp_rsp.source_list ||
		    got.empty_res !== exp_rsp.empty_res) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"%0t: response mismatch exp value=%0d list=%0d empty=%0b,",
					" got value=%0d list=%0d empty=%0b"},
					$realtime, exp_rsp.min_value, exp_rsp.source_list, exp_rsp.empty_res,
					got.min_value, got.source_list, got.empty_res);
		end
	endfunction
endclass

module tb_k_way_sorted_merge_core;
	import kwm_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int         ITEM_TARGET = 750;
	localparam int         QUIET_AFTER = 650;
	localparam int         STALL_LIMIT = 2000;
	localparam int         TAKE_CYCLES = LISTS_DEF + 3;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	req_item_t  req;
	logic       rsp_valid;
	logic       rsp_ready;
	rsp_item_t  rsp;

	merge_scoreboard order_check;
	int              items_sent;
	bit              quiet;
	int              idle_cycles;
	int              ready_hold;

	k_way_sorted_merge_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: ready in random bursts, steady once the run goes quiet
	initial ready_hold = 0;
	always @(posedge clk) begin
		if (ready_hold == 0) begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				rsp_ready  <= 1'b0;
				ready_hold = $urandom_range(0, 12);
			end else begin
				rsp_ready  <= 1'b1;
				ready_hold = $urandom_range(0, 23);
			end
		end else begin
			ready_hold--;
		end
	end

	// Response monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			order_check.check_response(rsp);
	end

	// Watchdog on cycles with no item moving either way
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	function automatic req_item_t make_req(logic [1:0] m, logic [2:0] id, logic [31:0] v);
		req_item_t item;
		item.mode    = m;
		item.list_id = id;
		item.value   = v;
		return item;
	endfunction

	// Next value of an ascending list; first value spread over the whole range
	function automatic logic signed [31:0] next_sorted(logic signed [31:0] prev, bit first);
		longint nxt;
		if (first) begin
			case ($urandom_range(0, 3))
				0: nxt = longint'($signed($urandom()));
				1: nxt = longint'($urandom_range(0, 40)) - 20;
				2: nxt = -64'sd2147483648 + longint'($urandom_range(0, 40));
				default: nxt = 64'sd2147483647 - longint'($urandom_range(0, 40));
			endcase
		end else begin
			case ($urandom_range(0, 3))
				0: nxt = longint'(prev);
				1: nxt = longint'(prev) + longint'($urandom_range(1, 8));
				2: nxt = longint'(prev) + longint'($urandom_range(1, 100000));
				default: nxt = longint'(prev) + (64'sd1 <<< $urandom_range(0, 30));
			endcase
			if (nxt > 64'sd2147483647)
				nxt = 64'sd2147483647;
		end
		return nxt[31:0];
	endfunction

	// Present one item, hold it until accepted; optional gap before it
	task automatic send_request(input req_item_t item);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		order_check.note_request(item);
		if (item.mode != MODE_UNUSED)
			items_sent++;
		quiet = (items_sent >= QUIET_AFTER);
	endtask

	task automatic send_take();
		send_request(make_req(MODE_TAKE, 3'($urandom()), $urandom()));
	endtask

	// Well-formed merge: sorted lists interleaved, then takes with late tail appends
	task automatic run_merge_job();
		int                 left [LISTS_DEF];
		logic signed [31:0] last [LISTS_DEF];
		bit                 started [LISTS_DEF];
		int                 total;
		int                 k;
		int                 takes;
		if ($urandom_range(0, 2) != 0)
			send_request(make_req(MODE_CLEAR, 3'($urandom()), $urandom()));
		total = 0;
		for (int i = 0; i < LISTS_DEF; i++) begin
			left[i]    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
			started[i] = 1'b0;
			last[i]    = '0;
			total     += left[i];
		end
		for (int n = 0; n < total; n++) begin
			k = $urandom_range(0, LISTS_DEF - 1);
			while (left[k] == 0)
				k = (k + 1) % LISTS_DEF;
			last[k]    = next_sorted(last[k], !started[k]);
			started[k] = 1'b1;
			left[k]--;
			send_request(make_req(MODE_APPEND, 3'(k), last[k]));
		end
		takes = total + $urandom_range(0, 2);
		for (int n = 0; n < takes; n++) begin
			if ($urandom_range(0, 5) == 0) begin
				k       = $urandom_range(0, LISTS_DEF - 1);
				last[k] = next_sorted(last[k], !started[k]);
				started[k] = 1'b1;
				send_request(make_req(MODE_APPEND, 3'(k), last[k]));
			end
			send_take();
		end
	endtask

	// Fill one list past its depth, then drain it completely
	task automatic run_full_list();
		int                 k;
		logic signed [31:0] v;
		k = $urandom_range(0, LISTS_DEF - 1);
		v = '0;
		send_request(make_req(MODE_CLEAR, '0, '0));
		for (int n = 0; n < LIST_DEPTH_DEF + 3; n++) begin
			v = next_sorted(v, n == 0);
			send_request(make_req(MODE_APPEND, 3'(k), v));
		end
		repeat (LIST_DEPTH_DEF + 1) send_take();
	endtask

	// Random items of any mode
	task automatic run_noise();
		int count;
		count = $urandom_range(1, 6);
		repeat (count)
			send_request(make_req(2'($urandom_range(0, 3)), 3'($urandom()), $urandom()));
	endtask

	// Main sequence
	initial begin
		bit did_fill;
		int pick;
		order_check = new();
		items_sent  = 0;
		quiet       = 1'b0;
		did_fill    = 1'b0;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		rsp_ready   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty take, field extremes, ties, unused mode, late append, clear
		send_take();
		send_request(make_req(MODE_APPEND, 3'd0, 32'h8000_0000));
		send_request(make_req(MODE_APPEND, 3'd7, 32'h7FFF_FFFF));
		send_request(make_req(MODE_APPEND, 3'd3, 32'hFFFF_FFFF));
		send_request(make_req(MODE_APPEND, 3'd3, 32'h0000_0000));
		send_request(make_req(MODE_APPEND, 3'd5, 32'h5555_5555));
		send_request(make_req(MODE_APPEND, 3'd2, 32'hAAAA_AAAA));
		send_request(make_req(MODE_APPEND, 3'd6, 32'd5));
		send_request(make_req(MODE_APPEND, 3'd1, 32'd5));
		send_request(make_req(MODE_UNUSED, 3'd7, 32'hFFFF_FFFF));
		send_request(make_req(MODE_TAKE, 3'd7, 32'hFFFF_FFFF));
		send_take();
		send_request(make_req(MODE_APPEND, 3'd0, -32'sd7));
		repeat (8) send_take();
		send_request(make_req(MODE_APPEND, 3'd4, 32'd123));
		send_request(make_req(MODE_CLEAR, 3'd7, 32'hFFFF_FFFF));
		send_take();

		// Random part, mostly well-formed merges
		while (items_sent < ITEM_TARGET) begin
			if (!did_fill && items_sent > 300) begin
				run_full_list();
				did_fill = 1'b1;
			end
			pick = $urandom_range(0, 9);
			if (pick < 6)
				run_merge_job();
			else if (pick < 9)
				run_noise();
			else
				send_request(make_req(MODE_CLEAR, 3'($urandom()), $urandom()));
		end
		req_valid <= 1'b0;

		// Drain and settle
		while (order_check.pending() > 0) @(posedge clk);
		repeat (TAKE_CYCLES + 8) @(posedge clk);
		if (order_check.mismatches == 0 && order_check.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[k_way_sorted_merge_core.f]
src/kwm_pkg.sv
src/kwm_cell.sv
src/k_way_sorted_merge_core.sv
verif/tb_k_way_sorted_merge_core.sv
